// ----- hdl/apq_pkg.sv -----
// apq_pkg: shared types, codes and the duration lookup for the alert priority queue
// used by apq_cell and alert_priority_queue; depends on nothing else
package apq_pkg;

	// queue size default and fixed field widths
	localparam int unsigned QueueDepthDef = 16;
	localparam int unsigned PicW   = 8;
	localparam int unsigned MsgW   = 8;
	localparam int unsigned PriW   = 4;
	localparam int unsigned BuzW   = 4;
	localparam int unsigned StampW = 16;
	localparam int unsigned DurW   = 13;
	localparam int unsigned StatW  = 2;
	localparam int unsigned CountOutW = 5;

	// operation codes carried in tuser
	localparam logic MODE_ADD    = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// status codes of one step
	localparam logic [StatW-1:0] ST_DONE      = 2'd0;
	localparam logic [StatW-1:0] ST_DUPLICATE = 2'd1;
	localparam logic [StatW-1:0] ST_FULL      = 2'd2;
	localparam logic [StatW-1:0] ST_EMPTY     = 2'd3;

	// display durations in milliseconds
	localparam logic [DurW-1:0] DUR_PRI1    = 13'd5000;
	localparam logic [DurW-1:0] DUR_PRI2    = 13'd3000;
	localparam logic [DurW-1:0] DUR_DEFAULT = 13'd1000;

	// one queued alert
	typedef struct packed {
		logic [StampW-1:0] stamp;
		logic [BuzW-1:0]   buz;
		logic [PriW-1:0]   pri;
		logic [MsgW-1:0]   msg;
		logic [PicW-1:0]   pic;
	} apq_entry_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic       ins;
		logic       rem;
		apq_entry_t item;
	} apq_ctrl_t;

	// display duration for a priority
	function automatic logic [DurW-1:0] duration_of(input logic [PriW-1:0] pri);
		logic [DurW-1:0] dur;
		case (pri)
			4'd1:    dur = DUR_PRI1;
			4'd2:    dur = DUR_PRI2;
			default: dur = DUR_DEFAULT;
		endcase
		return dur;
	endfunction

endpackage

// ----- hdl/apq_cell.sv -----
// apq_cell: one slot of the systolic priority queue, holds an alert and its valid bit
// depends on apq_pkg; instantiated in a row by alert_priority_queue
module apq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  apq_pkg::apq_ctrl_t  ctrl,
	input  apq_pkg::apq_entry_t prev_entry,
	input  logic                prev_valid,
	input  logic                prev_ge,
	input  apq_pkg::apq_entry_t next_entry,
	input  logic                next_valid,
	input  logic [7:0]          unique_id,
	output apq_pkg::apq_entry_t entry,
	output logic                valid,
	output logic                ge,
	output logic                dup_hit,
	output apq_pkg::apq_entry_t entry_d,
	output logic                valid_d
);
	import apq_pkg::*;

	apq_entry_t entry_q;
	logic       valid_q;

	// new alert belongs at or ahead of this slot; empty slots sort last
	assign ge      = !valid_q || (entry_q.pri >= ctrl.item.pri);
	assign dup_hit = valid_q && (entry_q.pic == unique_id);
	assign entry   = entry_q;
	assign valid   = valid_q;

	// next slot contents: shift down on insert, shift up on remove
	always_comb begin
		entry_d = entry_q;
		valid_d = valid_q;
		if (ctrl.ins && ge) begin
			if (prev_ge) begin
				entry_d = prev_entry;
				valid_d = prev_valid;
			end else begin
				entry_d = ctrl.item;
				valid_d = 1'b1;
			end
		end else if (ctrl.rem) begin
			entry_d = next_entry;
			valid_d = next_valid;
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ----- hdl/alert_priority_queue.sv -----
// alert_priority_queue: top level, a row of apq_cell slots with count, stamp and output register
// depends on apq_pkg and apq_cell
// result: the result word is registered and shows on m_tvalid in the cycle after the input word is taken
// throughput: one word per cycle while m_tready is high; every slot updates in parallel
// reset: clears slot valid bits, count, insertion stamp, unique picture id and output valid
// slot payloads are not cleared; no clearing pass is needed after reset
module alert_priority_queue #(
	parameter int unsigned QUEUE_DEPTH = apq_pkg::QueueDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,  // unique_picture_id
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // picture_id, message_id, priority_req, buzzer_type
	input  logic        s_tuser,    // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata     // status, head_valid, head_picture, head_message,
	                                // head_priority, head_buzzer, head_duration,
	                                // head_stamp, alert_count, zero fill
);
	import apq_pkg::*;

	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	logic [7:0]        unique_q;
	logic [CntW-1:0]   count_q;
	logic [StampW-1:0] stamp_q;
	logic              m_tvalid_q;
	logic [63:0]       m_tdata_q;

	apq_ctrl_t  ctrl;
	apq_entry_t cell_ent  [QUEUE_DEPTH];
	apq_entry_t cell_ent_d[QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_valid;
	logic [QUEUE_DEPTH-1:0] cell_valid_d;
	logic [QUEUE_DEPTH-1:0] cell_ge;
	logic [QUEUE_DEPTH-1:0] cell_dup;

	logic            accept;
	logic            is_add;
	logic            dup;
	logic            full;
	logic            empty;
	logic [StatW-1:0] status;
	logic [CntW-1:0] count_d;
	logic [CntW+CountOutW-1:0] count_ext;
	apq_entry_t      head;
	logic            head_valid;
	logic [DurW-1:0] head_dur;

	// handshake: take a word whenever the output register is free or draining
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// operation decode
	assign is_add = (s_tuser == MODE_ADD);
	assign dup    = (s_tdata[7:0] == unique_q) && (|cell_dup);
	assign full   = (count_q == CntW'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);

	always_comb begin
		ctrl.item.pic   = s_tdata[7:0];
		ctrl.item.msg   = s_tdata[15:8];
		ctrl.item.pri   = s_tdata[19:16];
		ctrl.item.buz   = s_tdata[23:20];
		ctrl.item.stamp = stamp_q;
		ctrl.ins        = 1'b0;
		ctrl.rem        = 1'b0;
		status          = ST_DONE;
		count_d         = count_q;
		if (is_add) begin
			if (dup) begin
				status = ST_DUPLICATE;
			end else if (full) begin
				status = ST_FULL;
			end else begin
				ctrl.ins = accept;
				count_d  = count_q + CntW'(1);
			end
		end else begin
			if (empty) begin
				status = ST_EMPTY;
			end else begin
				ctrl.rem = accept;
				count_d  = count_q - CntW'(1);
			end
		end
	end

	// chain of slots, slot 0 is the head
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		apq_entry_t prev_ent;
		apq_entry_t next_ent;
		logic       prev_vld;
		logic       prev_g;
		logic       next_vld;

		if (i == 0) begin : g_first
			assign prev_ent = '0;
			assign prev_vld = 1'b0;
			assign prev_g   = 1'b0;
		end else begin : g_mid
			assign prev_ent = cell_ent[i-1];
			assign prev_vld = cell_valid[i-1];
			assign prev_g   = cell_ge[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_ent = '0;
			assign next_vld = 1'b0;
		end else begin : g_inner
			assign next_ent = cell_ent[i+1];
			assign next_vld = cell_valid[i+1];
		end

		apq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_entry (prev_ent),
			.prev_valid (prev_vld),
			.prev_ge    (prev_g),
			.next_entry (next_ent),
			.next_valid (next_vld),
			.unique_id  (unique_q),
			.entry      (cell_ent[i]),
			.valid      (cell_valid[i]),
			.ge         (cell_ge[i]),
			.dup_hit    (cell_dup[i]),
			.entry_d    (cell_ent_d[i]),
			.valid_d    (cell_valid_d[i])
		);
	end

	// head after this step, zero when the queue ends up empty
	assign head_valid = cell_valid_d[0];
	assign head       = head_valid ? cell_ent_d[0] : '0;
	assign head_dur   = head_valid ? duration_of(cell_ent_d[0].pri) : '0;
	assign count_ext  = {{CountOutW{1'b0}}, count_d};

	// configuration, count and stamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unique_q <= '0;
			count_q  <= '0;
			stamp_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique_q <= cfg_wdata;
			end
			if (accept) begin
				count_q <= count_d;
			end
			if (ctrl.ins) begin
				stamp_q <= stamp_q + StampW'(1);
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	// output register word
	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {3'b000, count_ext[CountOutW-1:0], head.stamp, head_dur,
				head.buz, head.pri, head.msg, head.pic, head_valid, status};
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: sends add and remove words to alert_priority_queue and checks every result word
// against a queue model kept in this file; depends on apq_pkg and the alert_priority_queue rtl
module testbench;
	import apq_pkg::*;

	localparam int unsigned DEPTH        = QueueDepthDef;
	localparam int unsigned RANDOM_WORDS = 500;

	// result word layout, highest field first
	typedef struct packed {
		logic [2:0]           fill;
		logic [CountOutW-1:0] alert_count;
		logic [StampW-1:0]    head_stamp;
		logic [DurW-1:0]      head_duration;
		logic [BuzW-1:0]      head_buzzer;
		logic [PriW-1:0]      head_priority;
		logic [MsgW-1:0]      head_message;
		logic [PicW-1:0]      head_picture;
		logic                 head_valid;
		logic [StatW-1:0]     status;
	} head_report_t;

	// receiver stall patterns
	typedef enum int unsigned {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;  // picture_id, message_id, priority_req, buzzer_type
	logic        s_tuser   = MODE_ADD;  // mode
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;  // status, head_valid, head_picture, head_message, head_priority,
	                       // head_buzzer, head_duration, head_stamp, alert_count, zero fill

	// queue model and the result words still owed by the block
	apq_entry_t        alert_store[$];
	logic [PicW-1:0]   model_unique_pic = '0;
	logic [StampW-1:0] model_stamp      = '0;
	head_report_t      heads_due[$];
	int unsigned       mismatch_count = 0;
	int unsigned       burst_left     = 0;
	rx_pattern_t       rx_pattern     = RX_OPEN;
	int unsigned       rx_tick        = 0;

	alert_priority_queue #(
		.QUEUE_DEPTH(DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock, period 10
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// display time for a head alert
	function automatic logic [DurW-1:0] display_ms(input logic [PriW-1:0] pri);
		if (pri == 4'd1)
			return DUR_PRI1;
		if (pri == 4'd2)
			return DUR_PRI2;
		return DUR_DEFAULT;
	endfunction

	// apply one accepted word to the model and queue the result word it must produce
	function automatic void apply_alert_op(input logic mode, input apq_entry_t item);
		head_report_t     rep;
		logic [StatW-1:0] st;
		int               pos;
		st = ST_DONE;
		if (mode == MODE_REMOVE) begin
			if (alert_store.size() == 0)
				st = ST_EMPTY;
			else
				void'(alert_store.pop_front());
		end else begin
			// unique picture check wins over the full check
			if (item.pic == model_unique_pic)
				foreach (alert_store[i])
					if (alert_store[i].pic == item.pic)
						st = ST_DUPLICATE;
			if (st == ST_DONE && alert_store.size() >= DEPTH)
				st = ST_FULL;
			if (st == ST_DONE) begin
				// goes ahead of every alert with equal or larger priority number
				pos = 0;
				while (pos < alert_store.size() && alert_store[pos].pri < item.pri)
					pos++;
				item.stamp = model_stamp;
				alert_store.insert(pos, item);
				model_stamp++;
			end
		end
		rep        = '0;
		rep.status = st;
		if (alert_store.size() != 0) begin
			rep.head_valid    = 1'b1;
			rep.head_picture  = alert_store[0].pic;
			rep.head_message  = alert_store[0].msg;
			rep.head_priority = alert_store[0].pri;
			rep.head_buzzer   = alert_store[0].buz;
			rep.head_duration = display_ms(alert_store[0].pri);
			rep.head_stamp    = alert_store[0].stamp;
		end
		rep.alert_count = CountOutW'(alert_store.size());
		heads_due = {heads_due, rep};
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// result word checker and receiver stall pattern
	always @(posedge clk) begin
		head_report_t got;
		head_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (heads_due.size() == 0) begin
				$error("result word with no word sent for it: %h", m_tdata);
				mismatch_count++;
			end else begin
				want = heads_due.pop_front();
				check_field("status", want.status, got.status);
				check_field("head_valid", want.head_valid, got.head_valid);
				check_field("head_picture", want.head_picture, got.head_picture);
				check_field("head_message", want.head_message, got.head_message);
				check_field("head_priority", want.head_priority, got.head_priority);
				check_field("head_buzzer", want.head_buzzer, got.head_buzzer);
				check_field("head_duration", want.head_duration, got.head_duration);
				check_field("head_stamp", want.head_stamp, got.head_stamp);
				check_field("alert_count", want.alert_count, got.alert_count);
				check_field("zero fill", want.fill, got.fill);
			end
		end
		rx_tick++;
		if (rx_tick % 128 == 0)
			rx_pattern = rx_pattern_t'($urandom_range(0, 3));
		case (rx_pattern)
			RX_OPEN:  m_tready <= 1'b1;
			RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
			default:  m_tready <= ((rx_tick % 5) < 2);
		endcase
	end

	// send one word in bursts with random gaps, then update the model on acceptance
	task automatic send_word(input logic mode, input logic [7:0] pic, input logic [7:0] msg,
			input logic [3:0] pri, input logic [3:0] buz);
		apq_entry_t  item;
		int unsigned gap;
		item = '{stamp: '0, buz: buz, pri: pri, msg: msg, pic: pic};
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {buz, pri, msg, pic};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_alert_op(mode, item);
		burst_left--;
	endtask

	// only called while the block is idle
	task automatic write_unique_pic(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		model_unique_pic = value;
	endtask

	// stop sending and wait for every owed result word plus the output register
	task automatic idle_until_drained();
		s_tvalid <= 1'b0;
		while (heads_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// remove on empty, field extremes and a duplicate of the reset unique picture
	task automatic test_empty_queue();
		write_unique_pic(8'h00);
		send_word(MODE_REMOVE, 8'hFF, 8'hFF, 4'hF, 4'hF);
		send_word(MODE_ADD, 8'h00, 8'hFF, 4'h0, 4'hF);
		send_word(MODE_ADD, 8'h00, 8'h12, 4'h7, 4'h3);
		send_word(MODE_ADD, 8'hFF, 8'h00, 4'hF, 4'h0);
		send_word(MODE_REMOVE, 8'h00, 8'h00, 4'h0, 4'h0);
		send_word(MODE_REMOVE, 8'h00, 8'h00, 4'h0, 4'h0);
		send_word(MODE_REMOVE, 8'h00, 8'h00, 4'h0, 4'h0);
	endtask

	// priority order, newest first on ties, every duration and a duplicate of the top id
	task automatic test_priority_order();
		idle_until_drained();
		write_unique_pic(8'hFF);
		send_word(MODE_ADD, 8'hFF, 8'h80, 4'hF, 4'h1);
		send_word(MODE_ADD, 8'h01, 8'h81, 4'h3, 4'h2);
		send_word(MODE_ADD, 8'h02, 8'h82, 4'h2, 4'h4);
		send_word(MODE_ADD, 8'h03, 8'h83, 4'h1, 4'h8);
		send_word(MODE_ADD, 8'h04, 8'h84, 4'h1, 4'h5);
		send_word(MODE_ADD, 8'h05, 8'h85, 4'h0, 4'hA);
		send_word(MODE_ADD, 8'hFF, 8'h86, 4'h3, 4'h6);
		send_word(MODE_ADD, 8'h06, 8'h87, 4'h3, 4'h9);
		repeat (8) send_word(MODE_REMOVE, 8'h00, 8'h00, 4'h0, 4'h0);
	endtask

	// phases of filling, mixed and draining traffic, each after a new write of the unique picture
	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned phase;
		int unsigned phase_len;
		int unsigned add_pct;
		logic        mode;
		logic [7:0]  pic;
		logic [3:0]  pri;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			idle_until_drained();
			case (phase % 4)
				0:       write_unique_pic(8'h00);
				1:       write_unique_pic(8'hFF);
				default: write_unique_pic(8'($urandom_range(0, 255)));
			endcase
			case (phase % 3)
				0:       add_pct = 85;
				1:       add_pct = 50;
				default: add_pct = 20;
			endcase
			phase_len = $urandom_range(40, 80);
			// last phase stops at the word budget
			if (phase_len > RANDOM_WORDS - sent)
				phase_len = RANDOM_WORDS - sent;
			repeat (phase_len) begin
				mode = ($urandom_range(1, 100) <= add_pct) ? MODE_ADD : MODE_REMOVE;
				// the unique picture often, to hit duplicates
				pic  = ($urandom_range(0, 3) == 0) ? model_unique_pic : 8'($urandom);
				// a narrow priority range half the time, to get ties
				pri  = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
				send_word(mode, pic, 8'($urandom), pri, 4'($urandom));
				sent++;
			end
			phase++;
		end
	endtask

	// reset once, run the tests, then drain and report
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_priority_order();
		test_random_traffic();
		idle_until_drained();
		repeat (2) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
